FILE: hdl/cpfv_pkg.sv
// ----------------------------------------------------------------------------
// cpfv_pkg
// Shared types, constants and mod-11 helpers for the CPF check-digit validator.
// ----------------------------------------------------------------------------
package cpfv_pkg;

   // Input word: one raw character of the number plus its end flag
   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } req_type;

   // Result word
   typedef struct packed {
      logic       valid_res;
      logic [3:0] digit_count;
   } rsp_type;

   // Classified character passed from the front to the back
   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic       last;
   } item_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [3:0] DIGIT_LIMIT = 4'd15;
   localparam logic [3:0] CPF_LEN     = 4'd11;
   localparam logic [3:0] FIRST_SPAN  = 4'd9;
   localparam logic [3:0] SECOND_SPAN = 4'd10;
   localparam logic [3:0] FIRST_TOP   = 4'd10;
   localparam logic [3:0] SECOND_TOP  = 4'd11;
   localparam logic [3:0] MODULUS     = 4'd11;

   // Reduce a value below 128 modulo 11 (reciprocal 187/2048 is exact here)
   function automatic logic [3:0] mod11(input logic [6:0] x);
      logic [14:0] prod;
      logic [3:0]  quot;
      logic [6:0]  back;
      logic [6:0]  rem;
      prod = 15'(x) * 15'd187;
      quot = prod[14:11];
      back = 7'(quot) * 7'(MODULUS);
      rem  = x - back;
      return rem[3:0];
   endfunction

   // Check digit from the running sum modulo 11: (10 * s) mod 11, ten maps to zero
   function automatic logic [3:0] check_digit(input logic [3:0] res);
      logic [3:0] val;
      if (res <= 4'd1) begin
         val = 4'd0;
      end else begin
         val = MODULUS - res;
      end
      return val;
   endfunction

endpackage

FILE: hdl/cpfv_front.sv
// ----------------------------------------------------------------------------
// cpfv_front
// Front end: classify each incoming character as digit or separator.
// ----------------------------------------------------------------------------
module cpfv_front (
   input  cpfv_pkg::req_type  req_data,
   output cpfv_pkg::item_type item
);
   import cpfv_pkg::*;

   logic is_digit;

   // Detect ASCII digits; everything else only carries its end flag
   assign is_digit = (req_data.character >= CHAR_ZERO) && (req_data.character <= CHAR_NINE);

   // Build the classified word
   always_comb begin
      item.is_digit = is_digit;
      item.digit    = is_digit ? req_data.character[3:0] : 4'd0;
      item.last     = req_data.last;
   end

endmodule

FILE: hdl/cpfv_queue.sv
// ----------------------------------------------------------------------------
// cpfv_queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
module cpfv_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cpfv_pkg::item_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output cpfv_pkg::item_type head
);
   import cpfv_pkg::*;

   item_type               mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign head    = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("back end popped an empty queue");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with mismatched pointers");
`endif

endmodule

FILE: hdl/cpfv_back.sv
// ----------------------------------------------------------------------------
// cpfv_back
// Back end: accumulate mod-11 sums per digit and emit the verdict on the last word.
// ----------------------------------------------------------------------------
module cpfv_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  cpfv_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output cpfv_pkg::rsp_type  rsp_data
);
   import cpfv_pkg::*;

   logic [3:0] count_ff, count_in;
   logic [3:0] res1_ff, res1_in;
   logic [3:0] res2_ff, res2_in;
   logic [3:0] lead_ff, lead_in;
   logic       same_ff, same_in;
   logic [3:0] tenth_ff, tenth_in;
   logic [3:0] eleventh_ff, eleventh_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   logic       take;
   logic       use_digit;
   logic [3:0] pos;
   logic [3:0] w1;
   logic [3:0] w2;
   logic [6:0] prod1;
   logic [6:0] prod2;
   logic       ok;

   // Pop when there is room for a result, or the word makes none
   assign take      = item_valid && (!item.last || !out_valid_ff || rsp_pop);
   assign item_pop  = take;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   assign pos       = count_ff;
   assign use_digit = item.is_digit && (pos != DIGIT_LIMIT);
   assign w1        = FIRST_TOP - pos;
   assign w2        = SECOND_TOP - pos;
   assign prod1     = 7'(item.digit) * 7'(w1);
   assign prod2     = 7'(item.digit) * 7'(w2);

   // Update running residues and digit bookkeeping
   always_comb begin
      count_in    = count_ff;
      res1_in     = res1_ff;
      res2_in     = res2_ff;
      lead_in     = lead_ff;
      same_in     = same_ff;
      tenth_in    = tenth_ff;
      eleventh_in = eleventh_ff;
      if (use_digit) begin
         if (pos < FIRST_SPAN) begin
            res1_in = mod11(7'(res1_ff) + prod1);
         end
         if (pos < SECOND_SPAN) begin
            res2_in = mod11(7'(res2_ff) + prod2);
         end
         if (pos == '0) begin
            lead_in = item.digit;
         end else if (item.digit != lead_ff) begin
            same_in = 1'b0;
         end
         if (pos == FIRST_SPAN) begin
            tenth_in = item.digit;
         end
         if (pos == SECOND_SPAN) begin
            eleventh_in = item.digit;
         end
         count_in = pos + 4'd1;
      end
   end

   // Judge the number from the updated state
   assign ok = (count_in == CPF_LEN) && !same_in
               && (check_digit(res1_in) == tenth_in)
               && (check_digit(res2_in) == eleventh_in);

   // Load the result register on a last word, drop it when popped
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (take && item.last) begin
         out_valid_in       = 1'b1;
         out_in.valid_res   = ok;
         out_in.digit_count = count_in;
      end else if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         res1_ff      <= '0;
         res2_ff      <= '0;
         lead_ff      <= '0;
         same_ff      <= 1'b1;
         tenth_ff     <= '0;
         eleventh_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take && item.last) begin
            count_ff    <= '0;
            res1_ff     <= '0;
            res2_ff     <= '0;
            lead_ff     <= '0;
            same_ff     <= 1'b1;
            tenth_ff    <= '0;
            eleventh_ff <= '0;
         end else if (take) begin
            count_ff    <= count_in;
            res1_ff     <= res1_in;
            res2_ff     <= res2_in;
            lead_ff     <= lead_in;
            same_ff     <= same_in;
            tenth_ff    <= tenth_in;
            eleventh_ff <= eleventh_in;
         end
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

`ifndef NO_ASSERTIONS
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (res1_ff < MODULUS) && (res2_ff < MODULUS))
      else $error("running residue out of range");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && item.last) |=> (count_ff == '0) && same_ff)
      else $error("state not cleared after last word");
   a_valid_len: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.valid_res) |-> (out_ff.digit_count == CPF_LEN))
      else $error("valid verdict with wrong digit count");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff && $stable(out_ff))
      else $error("pending result overwritten");
`endif

endmodule

FILE: hdl/cpf_check_digit_validator.sv
// With an empty queue and no waiting result, a last character is written into the queue, and the
// back end then takes it from the queue head and loads the result register behind the rsp_ ports.
// Throughput: one character per cycle unless req_full; the accumulator takes one queued word per
// cycle, holding a last word while a result waits in its register; the queue keeps filling.
// Reset: synchronous, active high; empties the queue and the result register and clears the sums.
// ----------------------------------------------------------------------------
// cpf_check_digit_validator
// CPF mod-11 check-digit validator: characters in, one verdict per number out.
// ----------------------------------------------------------------------------
module cpf_check_digit_validator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cpfv_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cpfv_pkg::rsp_type rsp_data
);
   import cpfv_pkg::*;

   item_type class_item;
   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   // Classify characters
   cpfv_front u_front (
      .req_data (req_data),
      .item     (class_item)
   );

   // Decouple front and back
   cpfv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (class_item),
      .full      (req_full),
      .pop       (head_pop),
      .valid     (head_valid),
      .head      (head_item)
   );

   // Accumulate and judge
   cpfv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (head_valid),
      .item       (head_item),
      .item_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
